>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every rising edge of clk, reset cycles included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/llat_pkg.sv
// Shared types, constants and helpers of the torus automaton.
`timescale 1ns / 1ps

package llat_pkg;

  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;

  localparam int ColW   = $clog2(MaxWidth);
  localparam int RowW   = $clog2(MaxHeight);
  localparam int WActW  = $clog2(MaxWidth + 1);
  localparam int HActW  = $clog2(MaxHeight + 1);
  localparam int SizeW  = 7;
  localparam int MaskW  = 9;
  localparam int NbrW   = 4;
  localparam int XW     = 6;
  localparam int YW     = 6;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  typedef logic [MaxWidth-1:0] row_t;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_BIRTH    = 2'd2,
    CFG_SURVIVAL = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic shift_en;
    logic load_en;
  } cell_ctrl_t;

  function automatic logic [WActW-1:0] act_width(input logic [SizeW-1:0] r);
    int unsigned v;
    v = 32'(r);
    if (v == 0) v = 1;
    else if (v > MaxWidth) v = MaxWidth;
    return WActW'(v);
  endfunction

  function automatic logic [HActW-1:0] act_height(input logic [SizeW-1:0] r);
    int unsigned v;
    v = 32'(r);
    if (v == 0) v = 1;
    else if (v > MaxHeight) v = MaxHeight;
    return HActW'(v);
  endfunction

endpackage

>>> rtl/llat_cell.sv
// One row register of the rotating grid ring.
`timescale 1ns / 1ps

module llat_cell (
  input  logic                clk,
  input  logic                rst,
  input  llat_pkg::cell_ctrl_t ctrl,
  input  llat_pkg::row_t      shift_in,
  input  llat_pkg::row_t      load_data,
  output llat_pkg::row_t      row_q
);
  import llat_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_q <= '0;
    end else if (ctrl.load_en) begin
      row_q <= load_data;
    end else if (ctrl.shift_en) begin
      row_q <= shift_in;
    end
  end

endmodule

>>> rtl/llat_row_update.sv
// Next-generation value of one row from itself and the rows above and below.
`timescale 1ns / 1ps

module llat_row_update (
  input  llat_pkg::row_t                   above,
  input  llat_pkg::row_t                   cur,
  input  llat_pkg::row_t                   below,
  input  logic [llat_pkg::WActW-1:0]       w_act,
  input  logic [llat_pkg::MaskW-1:0]       birth_mask,
  input  logic [llat_pkg::MaskW-1:0]       survival_mask,
  output llat_pkg::row_t                   new_row
);
  import llat_pkg::*;

  logic [ColW-1:0] wm1;

  assign wm1 = ColW'(w_act - WActW'(1));

  for (genvar gx = 0; gx < MaxWidth; gx++) begin : g_col
    localparam int XR = (gx == MaxWidth - 1) ? 0 : gx + 1;
    logic             a_l, c_l, b_l;
    logic             a_r, c_r, b_r;
    logic             at_right;
    logic [NbrW-1:0]  n;
    logic [MaskW-1:0] mask;

    // Left neighbor of column zero wraps to the last column in use.
    if (gx == 0) begin : g_left_wrap
      assign a_l = above[wm1];
      assign c_l = cur[wm1];
      assign b_l = below[wm1];
    end else begin : g_left
      assign a_l = above[gx-1];
      assign c_l = cur[gx-1];
      assign b_l = below[gx-1];
    end

    assign at_right = (wm1 == ColW'(gx));
    assign a_r = at_right ? above[0] : above[XR];
    assign c_r = at_right ? cur[0]   : cur[XR];
    assign b_r = at_right ? below[0] : below[XR];

    assign n = NbrW'(a_l) + NbrW'(above[gx]) + NbrW'(a_r)
             + NbrW'(b_l) + NbrW'(below[gx]) + NbrW'(b_r)
             + NbrW'(c_l) + NbrW'(c_r);

    assign mask = cur[gx] ? survival_mask : birth_mask;

    // Columns beyond the grid in use drop to dead.
    assign new_row[gx] = (WActW'(gx) < w_act) ? mask[n] : 1'b0;
  end

endmodule

>>> rtl/life_like_automaton_torus_top.sv
// Flow: an in-range read or write sweeps one full turn of the row ring, then hands on its result;
// a step also sweeps the ring through the row update unit and then rebuilds row zero in a fix
// state; on a grid with one row in use that fix walks the row one column per cycle.
// Out-of-range and unused requests go straight to the result. A new item is taken only
// once the last one has left for the output register.
// Reset: synchronous; clears every cell, sets width and height to 64,
// birth mask to 8 and survival mask to 12, and empties the output register.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module life_like_automaton_torus_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic [llat_pkg::XW-1:0]       cell_x,
  input  logic [llat_pkg::YW-1:0]       cell_y,
  input  logic                          cell_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          read_alive,
  output logic                          status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [llat_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [llat_pkg::CfgDataW-1:0] cfg_data
);
  import llat_pkg::*;

  localparam logic [HActW-1:0] LastRow = HActW'(MaxHeight - 1);

  logic [SizeW-1:0] grid_width, grid_height;
  logic [MaskW-1:0] birth_mask, survival_mask;
  logic [WActW-1:0] w_act;
  logic [HActW-1:0] h_act, h_last;

  state_t state, state_next;
  logic [HActW-1:0] cnt;
  logic [ColW-1:0]  col;
  req_t             req_q;
  logic [XW-1:0]    x_q;
  logic [YW-1:0]    y_q;
  logic             val_q;
  logic             res_alive, res_status;

  row_t ring [MaxHeight];
  row_t head, nxt, tail, fix_row, new_row, head_w, head_fix;
  row_t above_sel, cur_sel, below_sel;
  row_t first_copy, second_copy, last_copy, prev_row;
  cell_ctrl_t ctrl_head, ctrl_rest;

  logic in_accept, out_free, in_range, is_step, at_y, one_row;
  req_t req_in;

  assign req_in    = req_t'(req_type);
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign w_act   = act_width(grid_width);
  assign h_act   = act_height(grid_height);
  assign h_last  = h_act - HActW'(1);
  assign one_row = (h_act == HActW'(1));
  assign head    = ring[0];
  assign nxt     = ring[1];
  assign is_step = (req_q == REQ_STEP);
  assign at_y    = (cnt == HActW'(y_q));
  assign in_range = (WActW'(cell_x) < w_act) && (HActW'(cell_y) < h_act);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= SizeW'(64);
      grid_height   <= SizeW'(64);
      birth_mask    <= MaskW'(8);
      survival_mask <= MaskW'(12);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:    grid_width    <= cfg_data[SizeW-1:0];
        CFG_HEIGHT:   grid_height   <= cfg_data[SizeW-1:0];
        CFG_BIRTH:    birth_mask    <= cfg_data;
        CFG_SURVIVAL: survival_mask <= cfg_data;
      endcase
    end
  end

  // Row ring: each cell takes its upper neighbor; the last cell takes the processed head.
  for (genvar gk = 0; gk < MaxHeight; gk++) begin : g_ring
    row_t sin;
    if (gk == MaxHeight - 1) begin : g_tail
      assign sin = tail;
    end else begin : g_mid
      assign sin = ring[gk+1];
    end
    llat_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      ((gk == 0) ? ctrl_head : ctrl_rest),
      .shift_in  (sin),
      .load_data (fix_row),
      .row_q     (ring[gk])
    );
  end

  // The fix state rebuilds row zero once the wrapped row above it is known.
  // With one row in use the row above is row zero itself, rewritten in place
  // from the left, so walk it one column per cycle.
  always_comb begin
    if (state == ST_FIX) begin
      above_sel = one_row ? head : last_copy;
      cur_sel   = first_copy;
      below_sel = one_row ? first_copy : second_copy;
    end else begin
      above_sel = prev_row;
      cur_sel   = head;
      below_sel = (cnt == h_last) ? first_copy : nxt;
    end
  end

  llat_row_update u_row (
    .above         (above_sel),
    .cur           (cur_sel),
    .below         (below_sel),
    .w_act         (w_act),
    .birth_mask    (birth_mask),
    .survival_mask (survival_mask),
    .new_row       (new_row)
  );

  always_comb begin
    head_fix      = head;
    head_fix[col] = new_row[col];
  end

  assign fix_row = one_row ? head_fix : new_row;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          priority if (req_in == REQ_NONE) state_next = ST_DONE;
          else if (req_in == REQ_STEP)     state_next = ST_SWEEP;
          else if (!in_range)              state_next = ST_DONE;
          else                             state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (cnt == LastRow) state_next = is_step ? ST_FIX : ST_DONE;
      end
      ST_FIX: begin
        if (!one_row || (col == ColW'(MaxWidth - 1))) state_next = ST_DONE;
      end
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Ring control and tail data
  always_comb begin
    ctrl_head = '{shift_en: (state == ST_SWEEP), load_en: (state == ST_FIX)};
    ctrl_rest = '{shift_en: (state == ST_SWEEP), load_en: 1'b0};
    head_w = head;
    head_w[x_q] = val_q;
    if (is_step) begin
      priority if (cnt == '0) tail = head;
      else if (cnt < h_act)    tail = new_row;
      else                     tail = '0;
    end else if (at_y && (req_q == REQ_WRITE)) begin
      tail = head_w;
    end else begin
      tail = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      col   <= '0;
    end else begin
      state <= state_next;
      if (in_accept) cnt <= '0;
      else if (state == ST_SWEEP) cnt <= cnt + HActW'(1);
      if (in_accept) col <= '0;
      else if (state == ST_FIX) col <= col + ColW'(1);
    end
  end

  // Request hold and result capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_q      <= req_in;
      x_q        <= cell_x;
      y_q        <= cell_y;
      val_q      <= cell_value;
      res_alive  <= 1'b0;
      res_status <= ((req_in == REQ_WRITE) || (req_in == REQ_READ)) && !in_range;
    end else if ((state == ST_SWEEP) && (req_q == REQ_READ) && at_y) begin
      res_alive <= head[x_q];
    end
  end

  // Row copies taken during a generation
  always_ff @(posedge clk) begin
    if ((state == ST_SWEEP) && is_step) begin
      if (cnt == '0)          first_copy  <= head;
      if (cnt == HActW'(1))   second_copy <= head;
      if (cnt == h_last)      last_copy   <= head;
      prev_row <= head;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      read_alive <= res_alive;
      status     <= res_status;
    end
  end

  `ASSERT_CLK(a_sweep_end, (state == ST_SWEEP) && (cnt == LastRow) |=> (state == ST_FIX) || (state == ST_DONE), "sweep overran the ring")
  `ASSERT_CLK(a_done_hand, (state == ST_DONE) && out_free |=> out_valid && (state == ST_IDLE), "result not handed to output")
  `ASSERT_CLK(a_status_alive, out_valid && status |-> !read_alive, "flagged result carries a live cell")
  `ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> (state == ST_IDLE) && !out_valid, "not idle after reset")

endmodule
